[design/shell_word_tokenizer_macros.svh]
// Assertion macros for the tokenizer checker.
`ifndef SHELL_WORD_TOKENIZER_MACROS_SVH
`define SHELL_WORD_TOKENIZER_MACROS_SVH

// Property that must hold in the same cycle as its condition.
`define SWT_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tokenizer check failed");

// Property that must hold in the cycle after its condition.
`define SWT_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tokenizer check failed");

`endif

[design/swt_pkg.sv]
// Types, codes and constants shared by the shell word tokenizer modules.
package swt_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_RESULTS = 3;

  localparam logic [5:0] WORD_LIMIT_RESET = 6'd31;

  // Result kinds.
  localparam logic [2:0] KIND_CHAR     = 3'd0;
  localparam logic [2:0] KIND_WORD_END = 3'd1;
  localparam logic [2:0] KIND_LINE_OK  = 3'd2;
  localparam logic [2:0] KIND_TOO_MANY = 3'd3;
  localparam logic [2:0] KIND_QUOTE    = 3'd4;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    MODE_BETWEEN,
    MODE_WORD,
    MODE_SQ,
    MODE_DQ,
    MODE_DONE
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_TOO_MANY,
    ERR_QUOTE
  } err_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_char;
    logic [5:0] word_index;
  } result_t;

  // All results caused by one input item; count is 1 to 3.
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[design/swt_front.sv]
// Front end: accepts characters, tracks the quoting state and builds result groups.
module swt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        ch,
  input  logic              line_end,
  input  swt_pkg::q_stat_t  q_stat,
  output logic              push,
  output swt_pkg::entry_t   push_entry
);

  swt_pkg::mode_t  mode, mode_next;
  swt_pkg::err_t   err, err_next;
  logic            esc, esc_next;
  logic [5:0]      word_count, word_count_next;
  logic [5:0]      word_limit;
  logic            accept;
  logic [1:0]      n;
  logic            is_sep;
  logic            start_ok;
  logic [5:0]      cur_word;

  assign in_stall = q_stat.full;
  assign accept   = in_valid & ~q_stat.full;
  assign push     = accept & (n != 2'd0);
  assign is_sep   = (ch == swt_pkg::CH_SPACE) || (ch == swt_pkg::CH_TAB);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_limit <= swt_pkg::WORD_LIMIT_RESET;
    end else if (cfg_we) begin
      word_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= swt_pkg::MODE_BETWEEN;
      err        <= swt_pkg::ERR_NONE;
      esc        <= 1'b0;
      word_count <= 6'd0;
    end else if (accept) begin
      mode       <= mode_next;
      err        <= err_next;
      esc        <= esc_next;
      word_count <= word_count_next;
    end
  end

  always_comb begin
    mode_next       = mode;
    err_next        = err;
    esc_next        = esc;
    word_count_next = word_count;
    push_entry      = '0;
    n               = 2'd0;
    start_ok        = 1'b0;
    cur_word        = word_count - 6'd1;

    if (mode != swt_pkg::MODE_DONE) begin
      if (line_end || ch == swt_pkg::CH_NUL) begin
        // End of the text: flush a pending backslash, close an open word or flag an open quote.
        if (esc) begin
          push_entry.res[n] = '{swt_pkg::KIND_CHAR, swt_pkg::CH_BSLASH, cur_word};
          n = n + 2'd1;
          esc_next = 1'b0;
        end
        if (mode == swt_pkg::MODE_SQ || mode == swt_pkg::MODE_DQ) begin
          err_next = swt_pkg::ERR_QUOTE;
        end else if (mode == swt_pkg::MODE_WORD) begin
          push_entry.res[n] = '{swt_pkg::KIND_WORD_END, 8'd0, cur_word};
          n = n + 2'd1;
        end
        mode_next = swt_pkg::MODE_DONE;
      end else if (esc) begin
        push_entry.res[n] = '{swt_pkg::KIND_CHAR, ch, cur_word};
        n = n + 2'd1;
        esc_next = 1'b0;
      end else begin
        start_ok = 1'b1;
        if (mode == swt_pkg::MODE_BETWEEN) begin
          if (is_sep) begin
            start_ok = 1'b0;
          end else if (word_count >= word_limit) begin
            err_next  = swt_pkg::ERR_TOO_MANY;
            mode_next = swt_pkg::MODE_DONE;
            start_ok  = 1'b0;
          end else begin
            word_count_next = word_count + 6'd1;
            mode_next       = swt_pkg::MODE_WORD;
            cur_word        = word_count;
          end
        end
        if (start_ok) begin
          unique case (mode_next)
            swt_pkg::MODE_SQ: begin
              if (ch == swt_pkg::CH_SQUOTE) begin
                mode_next = swt_pkg::MODE_WORD;
              end else begin
                push_entry.res[n] = '{swt_pkg::KIND_CHAR, ch, cur_word};
                n = n + 2'd1;
              end
            end
            swt_pkg::MODE_DQ: begin
              if (ch == swt_pkg::CH_DQUOTE) begin
                mode_next = swt_pkg::MODE_WORD;
              end else if (ch == swt_pkg::CH_BSLASH) begin
                esc_next = 1'b1;
              end else begin
                push_entry.res[n] = '{swt_pkg::KIND_CHAR, ch, cur_word};
                n = n + 2'd1;
              end
            end
            default: begin
              if (ch == swt_pkg::CH_DQUOTE) begin
                mode_next = swt_pkg::MODE_DQ;
              end else if (ch == swt_pkg::CH_SQUOTE) begin
                mode_next = swt_pkg::MODE_SQ;
              end else if (ch == swt_pkg::CH_BSLASH) begin
                esc_next = 1'b1;
              end else if (is_sep) begin
                push_entry.res[n] = '{swt_pkg::KIND_WORD_END, 8'd0, cur_word};
                n = n + 2'd1;
                mode_next = swt_pkg::MODE_BETWEEN;
              end else begin
                push_entry.res[n] = '{swt_pkg::KIND_CHAR, ch, cur_word};
                n = n + 2'd1;
              end
            end
          endcase
        end
      end
    end

    if (line_end) begin
      // Line status, then a clean state for the next line.
      unique case (err_next)
        swt_pkg::ERR_NONE:     push_entry.res[n].kind = swt_pkg::KIND_LINE_OK;
        swt_pkg::ERR_TOO_MANY: push_entry.res[n].kind = swt_pkg::KIND_TOO_MANY;
        default:               push_entry.res[n].kind = swt_pkg::KIND_QUOTE;
      endcase
      push_entry.res[n].out_char   = 8'd0;
      push_entry.res[n].word_index = word_count_next;
      n = n + 2'd1;
      mode_next       = swt_pkg::MODE_BETWEEN;
      err_next        = swt_pkg::ERR_NONE;
      esc_next        = 1'b0;
      word_count_next = 6'd0;
    end

    push_entry.count = n;
  end

endmodule

[design/swt_queue.sv]
// Short queue of result groups between the front end and the output sequencer.
module swt_queue #(
  parameter int Depth = swt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  swt_pkg::entry_t   push_entry,
  input  logic              pop,
  output swt_pkg::entry_t   head,
  output swt_pkg::q_stat_t  q_stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  swt_pkg::entry_t   slots [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == FullCnt);
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[design/swt_back.sv]
// Back end: steps through the results of the head group, one transaction per cycle while out_stall is low.
module swt_back (
  input  logic              clk,
  input  logic              rst,
  input  swt_pkg::entry_t   head,
  input  swt_pkg::q_stat_t  q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        kind,
  output logic [7:0]        out_char,
  output logic [5:0]        word_index,
  output logic              last
);

  logic [1:0]       sub;
  logic             take;
  swt_pkg::result_t cur;

  assign out_valid  = ~q_stat.empty;
  assign cur        = head.res[sub];
  assign kind       = cur.kind;
  assign out_char   = cur.out_char;
  assign word_index = cur.word_index;
  assign last       = (sub == head.count - 2'd1);
  assign take       = out_valid & ~out_stall;
  assign pop        = take & last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 2'd0;
    end else if (take) begin
      sub <= last ? 2'd0 : sub + 2'd1;
    end
  end

endmodule

[design/shell_word_tokenizer.sv]
// Top level of the shell word tokenizer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   cfg     | in        | cfg_we               | cfg_wdata (word_limit)
//   in      | in        | in_valid / in_stall  | ch, line_end
//   out     | out       | out_valid / out_stall| kind, out_char, word_index, last
//
// One character is taken every cycle while the result queue has room; the parse state
// updates in that same cycle, so items follow back to back.
// Results leave the output one per cycle while out_stall is low; an item gives 0 to 3
// results, written to the result queue and shown once the groups ahead of them have left.
// in_stall rises only when the QueueDepth-entry result queue is full.
// Reset clears the parse state, empties the queue and sets word_limit to 31.
module shell_word_tokenizer #(
  parameter int QueueDepth = swt_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        line_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  out_char,
  output logic [5:0]  word_index,
  output logic        last
);

  logic              push;
  logic              pop;
  swt_pkg::entry_t   push_entry;
  swt_pkg::entry_t   head;
  swt_pkg::q_stat_t  q_stat;

  swt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .line_end   (line_end),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  swt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  swt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .out_char   (out_char),
    .word_index (word_index),
    .last       (last)
  );

endmodule

[design/swt_checker.sv]
// Port-level checker for the shell word tokenizer, bound to the top level.
`include "shell_word_tokenizer_macros.svh"

module swt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  kind,
  input logic [7:0]  out_char,
  input logic [5:0]  word_index,
  input logic        last
);

  logic is_status;
  logic is_word_result;

  assign is_status = (kind == swt_pkg::KIND_LINE_OK) || (kind == swt_pkg::KIND_TOO_MANY) ||
                     (kind == swt_pkg::KIND_QUOTE);
  assign is_word_result = (kind == swt_pkg::KIND_CHAR) || (kind == swt_pkg::KIND_WORD_END);

  // A line status is always the final result of its end-of-line marker.
  `SWT_ASSERT_NOW(a_status_last, clk, rst, out_valid && is_status, last)

  // Only word characters carry a character value.
  `SWT_ASSERT_NOW(a_char_zero, clk, rst, out_valid && kind != swt_pkg::KIND_CHAR,
                  out_char == 8'd0)

  // A word index always stays below the largest limit, 63.
  `SWT_ASSERT_NOW(a_word_index, clk, rst, out_valid && is_word_result,
                  word_index != 6'd63)

  // A stalled transaction stays on the port unchanged.
  `SWT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable({kind, out_char, word_index, last}))

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .out_char   (out_char),
  .word_index (word_index),
  .last       (last)
);
